// ----- rtl/bgnm_pkg.sv -----
package bgnm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field and register widths
    localparam int CFG_W = 11;
    localparam int THR_W = 4;
    localparam int CNT_W = 4;
    localparam int IDX_W = 2;

    // Derived sizes
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int VROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_GRID_WIDTH     = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT    = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_WALL_THRESHOLD = IDX_W'(2);

    // Item kinds
    localparam logic FUNC_CELL  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Reset values
    localparam logic [CFG_W-1:0] RST_GRID_WIDTH  = CFG_W'(64);
    localparam logic [CFG_W-1:0] RST_GRID_HEIGHT = CFG_W'(64);
    localparam logic [THR_W-1:0] RST_THRESHOLD   = THR_W'(4);
    localparam int RST_EFF_W = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
    localparam int RST_EFF_H = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;
    localparam logic [POS_W-1:0] RST_TOTAL = POS_W'(RST_EFF_W * RST_EFF_H);

    // One column of the 3x3 window, top to bottom
    typedef struct packed {
        logic up;
        logic mid;
        logic low;
    } t_col;

    function automatic logic [WD_W-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            eff_width = WD_W'(1);
        end else if (v32 > 32'(MAX_WIDTH)) begin
            eff_width = WD_W'(MAX_WIDTH);
        end else begin
            eff_width = WD_W'(v32);
        end
    endfunction

    function automatic logic [HT_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            eff_height = HT_W'(1);
        end else if (v32 > 32'(MAX_HEIGHT)) begin
            eff_height = HT_W'(MAX_HEIGHT);
        end else begin
            eff_height = HT_W'(v32);
        end
    endfunction

endpackage

// ----- rtl/bgnm_intf.sv -----
interface bgnm_in_if;
    logic valid;
    logic ready;
    logic func;
    logic cell_in;

    modport source (output valid, output func, output cell_in, input ready);
    modport sink (input valid, input func, input cell_in, output ready);
endinterface

interface bgnm_out_if;
    import bgnm_pkg::*;
    logic             valid;
    logic             ready;
    logic             wall_out;
    logic [CNT_W-1:0] neighbor_walls;
    logic             last_cell;

    modport source (output valid, output wall_out, output neighbor_walls,
                    output last_cell, input ready);
    modport sink (input valid, input wall_out, input neighbor_walls,
                  input last_cell, output ready);
endinterface

interface bgnm_cfg_if;
    import bgnm_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bgnm_line_ram.sv -----
module bgnm_line_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 2
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bgnm_col_cell.sv -----
module bgnm_col_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  bgnm_pkg::t_col i_col,
    output bgnm_pkg::t_col o_col
);
    import bgnm_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
endmodule

// ----- rtl/binary_grid_neighbor_majority_pass_unit.sv -----
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   func, cell_in
// o_out     out  valid/ready   wall_out, neighbor_walls, last_cell
// i_cfg     in   valid/ready   index, data (ready always high)
//
// One item per cycle while i_in.ready is high; a result passes the line RAM read,
// the window column shift and the count stage into the 4-entry result queue.
// Grids of one row (or one column of two rows) hold input while the window advances on padding.
// Synchronous active-low reset; the line RAM has no clearing pass (out-of-grid taps are masked).
// i_in.ready drops when the 4-entry result queue plus in-flight results is full,
// for one cycle after a size write, and while the window catches up on a small grid.
module binary_grid_neighbor_majority_pass_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bgnm_in_if.sink          i_in,
    bgnm_out_if.source       o_out,
    bgnm_cfg_if.sink         i_cfg
);
    import bgnm_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);
    localparam int WIN_COLS   = 3;
    localparam int NB         = 8;

    typedef struct packed {
        logic is_top;
        logic is_bottom;
        logic is_left;
        logic is_right;
        logic is_last;
    } t_bound;

    typedef struct packed {
        logic             valid;
        logic             res;
        logic             val;
        logic [COL_W-1:0] col;
        t_bound           bound;
    } t_stage_a;

    typedef struct packed {
        logic   valid;
        t_bound bound;
    } t_stage_b;

    typedef struct packed {
        logic             wall_out;
        logic [CNT_W-1:0] neighbor_walls;
        logic             last_cell;
    } t_result;

    // Configuration
    logic [CFG_W-1:0] r_width, r_height;
    logic [THR_W-1:0] r_thr;
    logic             r_settle;
    logic [POS_W-1:0] r_total;
    logic [WD_W-1:0]  eff_w;
    logic [HT_W-1:0]  eff_h;
    logic [WD_W+HT_W-1:0] prod;
    logic             cfg_we, size_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we  = i_cfg.valid && i_cfg.ready;
    assign size_we = cfg_we && (i_cfg.index == REG_GRID_WIDTH ||
                                i_cfg.index == REG_GRID_HEIGHT);
    assign eff_w = eff_width(r_width);
    assign eff_h = eff_height(r_height);
    assign prod  = (WD_W+HT_W)'(eff_w) * (WD_W+HT_W)'(eff_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_GRID_WIDTH;
            r_height <= RST_GRID_HEIGHT;
            r_thr    <= RST_THRESHOLD;
            r_settle <= 1'b0;
            r_total  <= RST_TOTAL;
        end else begin
            r_settle <= size_we;
            r_total  <= POS_W'(prod);
            if (cfg_we) begin
                case (i_cfg.index)
                    REG_GRID_WIDTH:     r_width  <= i_cfg.data;
                    REG_GRID_HEIGHT:    r_height <= i_cfg.data;
                    REG_WALL_THRESHOLD: r_thr    <= i_cfg.data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Result queue state (needed for input flow control)
    t_result          r_fifo [FIFO_DEPTH];
    logic [FP_W-1:0]  r_wp, r_rp;
    logic [FC_W-1:0]  r_fcnt;
    t_stage_a         r_s1;
    t_stage_b         r_s2;
    logic             room;

    assign room = ((FC_W+1)'(r_fcnt) + (FC_W+1)'(r_s1.res) + (FC_W+1)'(r_s2.valid))
                  < (FC_W+1)'(FIFO_DEPTH);

    // Stream bookkeeping: cells received and results released in this grid
    logic [POS_W-1:0] r_in_pos, r_out_pos, in_next;
    logic [SUM_W-1:0] need_sum;
    logic             r_owe;
    logic             acc, cell_take, grant, out_last;

    assign i_in.ready = !r_owe && !r_settle && room;
    assign acc       = i_in.valid && i_in.ready;
    assign cell_take = acc && (i_in.func == FUNC_CELL) && (r_in_pos < r_total);
    assign in_next   = r_in_pos + POS_W'(cell_take);
    assign need_sum  = SUM_W'(r_out_pos) + SUM_W'(eff_w) + SUM_W'(2);
    assign grant     = acc && ((SUM_W'(in_next) >= need_sum) || (in_next == r_total));
    assign out_last  = (r_out_pos + POS_W'(1)) == r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_we) begin
            r_in_pos  <= '0;
            r_out_pos <= '0;
        end else if (acc) begin
            if (grant && out_last) begin
                r_in_pos  <= '0;
                r_out_pos <= '0;
            end else begin
                r_in_pos  <= in_next;
                r_out_pos <= r_out_pos + POS_W'(grant);
            end
        end
    end

    // Window engine position: v = column/row of the cell entering the window,
    // o = column/row of the window center.
    logic [COL_W-1:0]  r_vcol, n_vcol, r_ocol, n_ocol;
    logic [VROW_W-1:0] r_vrow, n_vrow;
    logic [OROW_W-1:0] r_orow, n_orow;
    logic              n_owe;
    logic              eng_end, primed, shift_pad, shift, res;
    t_bound            bound;

    assign eng_end   = r_vrow >= VROW_W'(eff_h);
    assign primed    = (r_vrow >= VROW_W'(2)) || (r_vrow == VROW_W'(1) && r_vcol != '0);
    // past the grid the window advances on padding, only against released results
    assign shift_pad = eng_end && (grant || (r_owe && room));
    assign shift     = cell_take || shift_pad;
    assign res       = shift && primed;

    assign bound.is_top    = r_orow == '0;
    assign bound.is_bottom = HT_W'(r_orow) == eff_h - HT_W'(1);
    assign bound.is_left   = r_ocol == '0;
    assign bound.is_right  = WD_W'(r_ocol) == eff_w - WD_W'(1);
    assign bound.is_last   = bound.is_bottom && bound.is_right;

    always_comb begin
        n_vcol = r_vcol;
        n_vrow = r_vrow;
        n_ocol = r_ocol;
        n_orow = r_orow;
        n_owe  = r_owe;
        if (grant && !res) begin
            n_owe = 1'b1;
        end else if (res && !grant) begin
            n_owe = 1'b0;
        end
        if (res && bound.is_last) begin
            n_vcol = '0;
            n_vrow = '0;
            n_ocol = '0;
            n_orow = '0;
        end else if (shift) begin
            if (WD_W'(r_vcol) == eff_w - WD_W'(1)) begin
                n_vcol = '0;
                n_vrow = r_vrow + VROW_W'(1);
            end else begin
                n_vcol = r_vcol + COL_W'(1);
            end
            if (res) begin
                if (bound.is_right) begin
                    n_ocol = '0;
                    n_orow = r_orow + OROW_W'(1);
                end else begin
                    n_ocol = r_ocol + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_we) begin
            r_vcol <= '0;
            r_vrow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_owe  <= 1'b0;
        end else begin
            r_vcol <= n_vcol;
            r_vrow <= n_vrow;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
            r_owe  <= n_owe;
        end
    end

    // Stage A: line RAM read; bits [1] = two rows up, [0] = one row up
    logic [1:0] ram_rdata, line, ram_wdata;
    logic [1:0] r_fwd;
    logic       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s1.res   <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1.valid <= shift;
            r_s1.res   <= res;
            // one-column grids read the entry being written this cycle
            r_fwd_hit  <= shift && r_s1.valid && (r_vcol == r_s1.col);
        end
        r_s1.val   <= cell_take && i_in.cell_in;
        r_s1.col   <= r_vcol;
        r_s1.bound <= bound;
        r_fwd      <= ram_wdata;
    end

    assign line      = r_fwd_hit ? r_fwd : ram_rdata;
    assign ram_wdata = {line[0], r_s1.val};

    bgnm_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W),
        .DW    (2)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1.col),
        .i_wdata (ram_wdata),
        .i_raddr (r_vcol),
        .o_rdata (ram_rdata)
    );

    // Stage B: window columns, newest at index 0
    t_col new_col;
    t_col win_in [WIN_COLS];
    t_col win [WIN_COLS];

    assign new_col.up  = line[1];
    assign new_col.mid = line[0];
    assign new_col.low = r_s1.val;

    for (genvar k = 0; k < WIN_COLS; k++) begin : g_win
        if (k == 0) begin : g_head
            assign win_in[k] = new_col;
        end else begin : g_link
            assign win_in[k] = win[k-1];
        end
        bgnm_col_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_s1.valid),
            .i_col   (win_in[k]),
            .o_col   (win[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= r_s1.valid && r_s1.res;
        end
        r_s2.bound <= r_s1.bound;
    end

    // Stage C: count neighbors, out-of-grid taps read as walls
    logic [NB-1:0]    nb;
    logic [CNT_W-1:0] nb_cnt;
    t_result          result;
    t_bound           b2;

    assign b2 = r_s2.bound;
    assign nb[0] = win[2].up  | b2.is_top    | b2.is_left;
    assign nb[1] = win[2].mid | b2.is_left;
    assign nb[2] = win[2].low | b2.is_bottom | b2.is_left;
    assign nb[3] = win[1].up  | b2.is_top;
    assign nb[4] = win[1].low | b2.is_bottom;
    assign nb[5] = win[0].up  | b2.is_top    | b2.is_right;
    assign nb[6] = win[0].mid | b2.is_right;
    assign nb[7] = win[0].low | b2.is_bottom | b2.is_right;

    always_comb begin
        nb_cnt = '0;
        for (int k = 0; k < NB; k++) begin
            nb_cnt = nb_cnt + CNT_W'(nb[k]);
        end
    end

    assign result.wall_out       = nb_cnt > r_thr;
    assign result.neighbor_walls = nb_cnt;
    assign result.last_cell      = b2.is_last;

    // Result queue
    logic push, pop;

    assign push = r_s2.valid;
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + FP_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FP_W'(1);
            end
            r_fcnt <= r_fcnt + FC_W'(push) - FC_W'(pop);
        end
        if (push) begin
            r_fifo[r_wp] <= result;
        end
    end

    assign o_out.valid          = r_fcnt != '0;
    assign o_out.wall_out       = r_fifo[r_rp].wall_out;
    assign o_out.neighbor_walls = r_fifo[r_rp].neighbor_walls;
    assign o_out.last_cell      = r_fifo[r_rp].last_cell;

`ifndef SYNTHESIS
    a_owe_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owe |-> !i_in.ready)
        else $error("input taken while window still owes a result");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FC_W+1)'(r_fcnt) + (FC_W+1)'(r_s1.res) + (FC_W+1)'(r_s2.valid)
            <= (FC_W+1)'(FIFO_DEPTH))
        else $error("result queue overcommitted");

    a_size_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        size_we |=> (r_in_pos == '0) && (r_out_pos == '0) && !r_owe &&
                    (r_vrow == '0) && (r_vcol == '0))
        else $error("size write did not restart the grid");
`endif
endmodule

// ----- dv/tb_binary_grid_neighbor_majority_pass_unit.sv -----
module tb_binary_grid_neighbor_majority_pass_unit;
    import bgnm_pkg::*;

    localparam int unsigned CLK_PERIOD       = 4;
    localparam int unsigned RESET_CYCLES     = 11;
    localparam int unsigned RUN_LIMIT_CYCLES = 3_000_000;
    localparam int unsigned RANDOM_ITEMS     = 200;
    localparam int unsigned SETTLE_CYCLES    = 10;
    localparam int unsigned MAX_REPORTS      = 50;
    localparam logic [IDX_W-1:0] REG_UNUSED  = IDX_W'(3);
    localparam logic [8:0] TINY_PATTERN      = 9'b110_011_101;

    typedef struct packed {
        logic func;
        logic cell_bit;
    } t_grid_item;

    typedef struct packed {
        logic             wall;
        logic [CNT_W-1:0] walls;
        logic             last;
    } t_smoothed_cell;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bgnm_in_if  in_if ();
    bgnm_out_if out_if ();
    bgnm_cfg_if cfg_if ();

    binary_grid_neighbor_majority_pass_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Smoothing predictor state: four row slots, sizes, threshold, positions
    logic             grid_rows [4*MAX_WIDTH];
    logic [CFG_W-1:0] sm_width  = RST_GRID_WIDTH;
    logic [CFG_W-1:0] sm_height = RST_GRID_HEIGHT;
    logic [THR_W-1:0] sm_thresh = RST_THRESHOLD;
    int unsigned      cells_in  = 0;
    int unsigned      cells_out = 0;

    t_grid_item     grid_items_q [$];
    t_smoothed_cell smoothed_due [$];

    int unsigned err_count      = 0;
    int unsigned results_seen   = 0;
    int unsigned in_gap_left    = 0;
    int unsigned out_stall_left = 0;
    logic        in_steady      = 1'b0;
    logic        out_steady     = 1'b0;
    t_grid_item  drv_item;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic int unsigned grid_w();
        return clamp_dim(sm_width, MAX_WIDTH);
    endfunction

    function automatic int unsigned grid_h();
        return clamp_dim(sm_height, MAX_HEIGHT);
    endfunction

    // Off-grid neighbors count as walls
    function automatic int unsigned wall_neighbors(input int unsigned row, input int unsigned col,
                                                   input int unsigned w, input int unsigned h);
        int unsigned n;
        int y, x, dy, dx;
        n = 0;
        for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
                y = int'(row) + dy;
                x = int'(col) + dx;
                if (dy == 0 && dx == 0) begin
                    continue;
                end
                if (y < 0 || x < 0 || y >= int'(h) || x >= int'(w)) begin
                    n++;
                end else if (grid_rows[(y % 4) * MAX_WIDTH + x]) begin
                    n++;
                end
            end
        end
        return n;
    endfunction

    function automatic void smooth_cell_step(input logic func, input logic cell_bit);
        int unsigned w, h, total, need, row, col, n;
        t_smoothed_cell r;
        w = grid_w();
        h = grid_h();
        total = w * h;
        // a cell arriving after the whole grid is in acts as a drain
        if (func == FUNC_CELL && cells_in < total) begin
            row = cells_in / w;
            col = cells_in % w;
            grid_rows[(row % 4) * MAX_WIDTH + col] = cell_bit;
            cells_in++;
        end
        if (cells_out >= total) begin
            return;
        end
        need = cells_out + w + 2;
        if (need > total) begin
            need = total;
        end
        if (cells_in < need) begin
            return;
        end
        row = cells_out / w;
        col = cells_out % w;
        n = wall_neighbors(row, col, w, h);
        r.wall  = (n > int'(sm_thresh));
        r.walls = CNT_W'(n);
        r.last  = (cells_out == total - 1);
        smoothed_due.push_back(r);
        cells_out++;
        if (cells_out >= total) begin
            cells_in  = 0;
            cells_out = 0;
        end
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            REG_GRID_WIDTH: begin
                sm_width  = val;
                cells_in  = 0;
                cells_out = 0;
            end
            REG_GRID_HEIGHT: begin
                sm_height = val;
                cells_in  = 0;
                cells_out = 0;
            end
            REG_WALL_THRESHOLD: begin
                sm_thresh = val[THR_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int unsigned idle_len();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(64, 12);
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_smoothed();
        t_smoothed_cell want;
        if (smoothed_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result wall=%0b walls=%0d last=%0b",
                                      out_if.wall_out, out_if.neighbor_walls, out_if.last_cell));
            return;
        end
        want = smoothed_due.pop_front();
        results_seen++;
        if (out_if.wall_out !== want.wall) begin
            report_mismatch($sformatf("result %0d wall_out %0b, want %0b",
                                      results_seen, out_if.wall_out, want.wall));
        end
        if (out_if.neighbor_walls !== want.walls) begin
            report_mismatch($sformatf("result %0d neighbor_walls %0d, want %0d",
                                      results_seen, out_if.neighbor_walls, want.walls));
        end
        if (out_if.last_cell !== want.last) begin
            report_mismatch($sformatf("result %0d last_cell %0b, want %0b",
                                      results_seen, out_if.last_cell, want.last));
        end
    endtask

    // Input driver: predicts on each accepted transaction, then presents the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.func    <= FUNC_DRAIN;
            in_if.cell_in <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                smooth_cell_step(in_if.func, in_if.cell_in);
                if (!in_steady && $urandom_range(99) < 30) begin
                    in_gap_left = idle_len();
                end
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap_left != 0) begin
                    in_gap_left--;
                    in_if.valid <= 1'b0;
                end else if (grid_items_q.size() != 0) begin
                    drv_item = grid_items_q.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.func    <= drv_item.func;
                    in_if.cell_in <= drv_item.cell_bit;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_smoothed();
            end
            if (out_stall_left != 0) begin
                out_stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!out_steady && $urandom_range(99) < 12) begin
                    out_stall_left = idle_len();
                end
            end
        end
    end

    function automatic void push_item(input logic func, input logic cell_bit);
        grid_items_q.push_back(t_grid_item'{func, cell_bit});
    endfunction

    task automatic wait_inputs_sent();
        while (grid_items_q.size() != 0 || in_if.valid) begin
            @(negedge i_clk);
        end
    endtask

    // Sender holds off until every expected result is out and the pipe has settled
    task automatic wait_quiet();
        wait_inputs_sent();
        while (smoothed_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        apply_reg(idx, val);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_cells(input int unsigned n, input int unsigned pct, input logic noisy);
        int unsigned k;
        for (k = 0; k < n; k++) begin
            if (noisy && $urandom_range(99) < 4) begin
                push_item(FUNC_DRAIN, 1'($urandom_range(1)));
            end
            if ($urandom_range(255) == 0) begin
                wait_quiet();
            end
            push_item(FUNC_CELL, ($urandom_range(99) < pct));
        end
    endtask

    // Once the whole grid is in, each drain (or stray cell) releases one result
    task automatic flush_grid(output int unsigned drains);
        int unsigned total;
        wait_inputs_sent();
        total = grid_w() * grid_h();
        drains = (cells_in == total && cells_out < total) ? total - cells_out : 0;
        repeat (drains) begin
            if ($urandom_range(99) < 12) begin
                push_item(FUNC_CELL, 1'($urandom_range(1)));
            end else begin
                push_item(FUNC_DRAIN, 1'($urandom_range(1)));
            end
        end
    endtask

    function automatic void set_pace();
        in_steady  = ($urandom_range(3) == 0);
        out_steady = ($urandom_range(3) == 0);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(input int unsigned maxd);
        if ($urandom_range(19) == 0) begin
            return '0;
        end
        return CFG_W'($urandom_range(maxd, 1));
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold();
        int unsigned nib;
        nib = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 0);
        return {(CFG_W-THR_W)'($urandom), THR_W'(nib)};
    endfunction

    function automatic int unsigned pick_density();
        case ($urandom_range(4))
            0: return 10;
            1: return 40;
            2: return 50;
            3: return 60;
            default: return 90;
        endcase
    endfunction

    initial begin : stimulus
        int unsigned budget, n, remain, pct, drains, k;
        logic size_due;
        in_if.valid   = 1'b0;
        in_if.func    = FUNC_DRAIN;
        in_if.cell_in = 1'b0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_GRID_WIDTH;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset config: drain with nothing pending, then the head of a 64-wide grid
        set_pace();
        push_item(FUNC_DRAIN, 1'b1);
        send_cells(40, 50, 1'b0);
        wait_quiet();
        send_cells(27, 50, 1'b0);
        wait_quiet();

        // 3x3 grid, abandoned once by a width write
        write_reg(REG_GRID_WIDTH, CFG_W'(3));
        write_reg(REG_GRID_HEIGHT, CFG_W'(3));
        write_reg(REG_WALL_THRESHOLD, CFG_W'(4));
        push_item(FUNC_CELL, 1'b1);
        push_item(FUNC_CELL, 1'b0);
        wait_quiet();
        write_reg(REG_GRID_WIDTH, CFG_W'(3));
        for (k = 0; k < 9; k++) begin
            push_item(FUNC_CELL, TINY_PATTERN[k]);
        end
        wait_inputs_sent();
        push_item(FUNC_CELL, 1'b1);
        flush_grid(drains);
        wait_quiet();

        // Zero sizes give a single cell with eight off-grid walls
        write_reg(REG_WALL_THRESHOLD, 11'h7F8);
        write_reg(REG_GRID_WIDTH, '0);
        write_reg(REG_GRID_HEIGHT, '0);
        write_reg(REG_UNUSED, 11'h7FF);
        push_item(FUNC_CELL, 1'b0);
        wait_quiet();
        write_reg(REG_WALL_THRESHOLD, CFG_W'(7));
        push_item(FUNC_CELL, 1'b1);
        wait_quiet();
        write_reg(REG_WALL_THRESHOLD, CFG_W'(15));
        push_item(FUNC_CELL, 1'b1);

        budget   = 0;
        size_due = 1'b1;
        while (budget < RANDOM_ITEMS) begin
            wait_quiet();
            set_pace();
            if (size_due || $urandom_range(2) == 0) begin
                write_reg(REG_GRID_WIDTH, pick_dim(12));
                if ($urandom_range(1) == 1) begin
                    write_reg(REG_GRID_HEIGHT, pick_dim(10));
                end
                size_due = 1'b0;
            end
            if ($urandom_range(2) == 0) begin
                write_reg(REG_WALL_THRESHOLD, pick_threshold());
            end
            if ($urandom_range(15) == 0) begin
                write_reg(REG_UNUSED, CFG_W'($urandom));
            end
            remain = grid_w() * grid_h() - cells_in;
            pct    = pick_density();
            if (remain > 1 && $urandom_range(9) == 0) begin
                // partial grid, dropped by the next size write
                n = $urandom_range(remain - 1, 1);
                send_cells(n, pct, 1'b1);
                budget  += n;
                size_due = 1'b1;
            end else begin
                send_cells(remain, pct, 1'b1);
                flush_grid(drains);
                budget += remain + drains;
            end
        end

        // Oversize width clamps to a full-width line; two rows, left unfinished
        wait_quiet();
        set_pace();
        write_reg(REG_GRID_WIDTH, 11'h7FF);
        write_reg(REG_GRID_HEIGHT, CFG_W'(2));
        write_reg(REG_WALL_THRESHOLD, pick_threshold());
        send_cells(MAX_WIDTH + 6, 50, 1'b1);
        wait_quiet();
        set_pace();
        // Oversize height on a single column, also left unfinished
        write_reg(REG_GRID_WIDTH, CFG_W'(1));
        write_reg(REG_GRID_HEIGHT, 11'h7FF);
        write_reg(REG_WALL_THRESHOLD, CFG_W'(5));
        send_cells(30, 50, 1'b1);

        wait_inputs_sent();
        while (smoothed_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4 * SETTLE_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("tb_binary_grid_neighbor_majority_pass_unit OK");
        end else begin
            $display("tb_binary_grid_neighbor_majority_pass_unit NOT OK");
        end
        $finish;
    end

    initial begin : run_limit
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("tb_binary_grid_neighbor_majority_pass_unit NOT OK");
        $finish;
    end

endmodule
